// ----- rtl/umrp_pkg.sv -----
// Shared types, register indexes and constants of the unfolding-model rejection probability block.
// Holds the power-of-two step constants used by umrp_exp; depends on nothing.
package umrp_pkg;

	localparam logic [1:0] REG_DISC = 2'd0;
	localparam logic [1:0] REG_LOC  = 2'd1;
	localparam logic [1:0] REG_THR  = 2'd2;

	localparam logic [15:0] DISC_RESET = 16'd4096;

	// Latencies in clock cycles of the exponential unit and the divider.
	localparam int EXP_LAT = 16;
	localparam int DIV_LAT = 17;

	typedef struct packed {
		logic        vld;
		logic [62:0] dividend;
		logic [46:0] divisor;
	} umrp_div_req_t;

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		longint unsigned rem;
		root = 0;
		bitv = 64'd1 << 62;
		rem  = v;
		for (int i = 0; i < 32; i++) begin
			if (rem >= root + bitv) begin
				rem  = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// 2^(2^k/4096) in Q30, built by repeated square roots from 2^0.5.
	function automatic logic [30:0] pow2_step(int k);
		longint unsigned c;
		c = isqrt(64'd1 << 61);
		for (int j = 10; j >= 0; j--) begin
			if (j >= k) begin
				c = isqrt(c << 30);
			end
		end
		return c[30:0];
	endfunction

endpackage

// ----- rtl/umrp_exp.sv -----
// Pipelined exponential unit: clamps a Q12 argument, changes base to two and builds 2^x in Q32.
// Uses umrp_pkg for the step constants; instantiated by the top level.
module umrp_exp (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] disc,
	input  logic signed [18:0] arg,
	output logic        [56:0] e
);

	localparam logic signed [22:0] XMIN = -23'sd65536;
	localparam logic signed [22:0] XMAX = 23'sd65535;

	logic signed [34:0] prod_s1;
	logic signed [22:0] x_full;
	logic signed [16:0] x_clamp;
	logic signed [30:0] yf_s2;
	logic signed [18:0] y;
	logic signed [6:0]  n_p [0:12];
	logic        [11:0] f_p [0:12];
	logic        [30:0] m_p [0:12];
	logic signed [7:0]  sh;
	logic signed [7:0]  nsh;
	logic        [56:0] e_comb;
	logic        [56:0] e_s16;

	always_comb begin
		x_full = prod_s1[34:12];
		if (x_full < XMIN) begin
			x_clamp = XMIN[16:0];
		end else if (x_full > XMAX) begin
			x_clamp = XMAX[16:0];
		end else begin
			x_clamp = x_full[16:0];
		end
		y = yf_s2[30:12];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 35'(disc) * 35'(arg);
			yf_s2   <= 31'(x_clamp) * 31'(14'sd5909);
			n_p[0]  <= y[18:12];
			f_p[0]  <= y[11:0];
		end
	end

	assign m_p[0] = 31'd1 << 30;

	// One rounded multiply per stage, for each set fraction bit.
	for (genvar k = 0; k < 12; k++) begin : g_pow
		localparam logic [30:0] C = umrp_pkg::pow2_step(k);
		logic [63:0] mul;
		assign mul = 64'(m_p[k]) * 64'(C) + (64'd1 << 29);
		always_ff @(posedge clk) begin
			if (en) begin
				m_p[k+1] <= f_p[k][k] ? mul[60:30] : m_p[k];
				f_p[k+1] <= f_p[k];
				n_p[k+1] <= n_p[k];
			end
		end
	end

	always_comb begin
		sh  = {n_p[12][6], n_p[12]} + 8'sd2;
		nsh = -sh;
		if (!sh[7]) begin
			e_comb = 57'(m_p[12]) << sh[4:0];
		end else begin
			e_comb = 57'(m_p[12]) >> nsh[4:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s16 <= e_comb;
		end
	end

	assign e = e_s16;

endmodule

// ----- rtl/umrp_div.sv -----
// Pipelined restoring divider that retires one quotient bit per stage.
// Takes its request struct from umrp_pkg; instantiated by the top level.
module umrp_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  umrp_pkg::umrp_div_req_t req,
	output logic                    q_vld,
	output logic [16:0]             q
);

	logic        v_p [0:17];
	logic [46:0] r_p [0:17];
	logic [62:0] n_p [0:17];
	logic [46:0] d_p [0:17];
	logic [16:0] q_p [0:17];

	assign v_p[0] = req.vld;
	assign r_p[0] = {1'b0, req.dividend[62:17]};
	assign n_p[0] = req.dividend;
	assign d_p[0] = req.divisor;
	assign q_p[0] = '0;

	for (genvar j = 0; j < 17; j++) begin : g_step
		logic [47:0] t;
		logic        ge;
		assign t  = {r_p[j], n_p[j][16-j]};
		assign ge = t >= {1'b0, d_p[j]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[j+1] <= 1'b0;
			end else if (en) begin
				v_p[j+1] <= v_p[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_p[j+1] <= ge ? 47'(t - {1'b0, d_p[j]}) : t[46:0];
				q_p[j+1] <= {q_p[j][15:0], ge};
				n_p[j+1] <= n_p[j];
				d_p[j+1] <= d_p[j];
			end
		end
	end

	assign q_vld = v_p[17];
	assign q     = q_p[17];

endmodule

// ----- rtl/unfolding_model_rejection_probability_top.sv -----
// Top level of the unfolding-model rejection probability block.
// Uses umrp_pkg, umrp_exp and umrp_div.
//
// Each trait transaction yields one probability transaction, and a new trait is taken every
// cycle unless stalled: two input stages, a 16-stage exponential unit (twelve of its stages
// are the fraction-bit multiplies), three sum and normalize stages, a 17-stage divider that
// retires one quotient bit per stage, and the output register. A skid register behind the
// output keeps the pipeline moving while a result waits; trait_stall rises only when both hold.
module unfolding_model_rejection_probability_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        trait_valid,
	output logic        trait_stall,
	input  logic [15:0] trait,
	output logic        probability_valid,
	input  logic        probability_stall,
	output logic [15:0] probability
);

	logic signed [15:0] disc_q, loc_q, thr_q;
	logic               en;
	logic               vld_s1, vld_s2, vld_sum, vld_nrm, vld_shf;
	logic               vld_x [0:umrp_pkg::EXP_LAT];
	logic signed [16:0] dd_s1;
	logic signed [18:0] dd19, u19;
	logic signed [18:0] arg1_s2, arg2_s2, arg3_s2;
	logic        [56:0] e1, e2, e3;
	logic        [58:0] num_c, num_sum, den_sum;
	logic        [58:0] num_nrm, den_nrm;
	logic        [3:0]  s_c, s_nrm;
	logic        [46:0] num_sh, den_sh;
	logic        [62:0] dvd_shf;
	logic        [46:0] dvs_shf;
	umrp_pkg::umrp_div_req_t req_shf;
	logic               dq_vld;
	logic        [16:0] dq;
	logic        [15:0] sat;
	logic               out_vld_q, skid_vld_q;
	logic        [15:0] out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disc_q <= umrp_pkg::DISC_RESET;
			loc_q  <= '0;
			thr_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				umrp_pkg::REG_DISC: disc_q <= cfg_data;
				umrp_pkg::REG_LOC:  loc_q  <= cfg_data;
				umrp_pkg::REG_THR:  thr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en          = !skid_vld_q;
	assign trait_stall = skid_vld_q;

	assign dd19 = 19'(dd_s1);
	assign u19  = 19'(thr_q);

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s1   <= 17'($signed(trait)) - 17'(loc_q);
			arg1_s2 <= dd19 - u19;
			arg2_s2 <= (dd19 <<< 1) - u19;
			arg3_s2 <= dd19 + (dd19 <<< 1);
		end
	end

	umrp_exp u_exp1 (.clk(clk), .en(en), .disc(disc_q), .arg(arg1_s2), .e(e1));
	umrp_exp u_exp2 (.clk(clk), .en(en), .disc(disc_q), .arg(arg2_s2), .e(e2));
	umrp_exp u_exp3 (.clk(clk), .en(en), .disc(disc_q), .arg(arg3_s2), .e(e3));

	assign vld_x[0] = vld_s2;

	for (genvar i = 0; i < umrp_pkg::EXP_LAT; i++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_x[i+1] <= 1'b0;
			end else if (en) begin
				vld_x[i+1] <= vld_x[i];
			end
		end
	end

	// The shift count is the number of bits the denominator reaches above bit 46.
	always_comb begin
		num_c = (59'd1 << 32) + 59'(e3);
		s_c   = '0;
		for (int j = 0; j < 13; j++) begin
			s_c = s_c + 4'((den_sum >> (47 + j)) != 59'd0);
		end
		num_sh = 47'(num_nrm >> s_nrm);
		den_sh = 47'(den_nrm >> s_nrm);
		sat    = dq[16] ? 16'hFFFF : dq[15:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_sum <= num_c;
			den_sum <= num_c + 59'(e1) + 59'(e2);
			num_nrm <= num_sum;
			den_nrm <= den_sum;
			s_nrm   <= s_c;
			dvd_shf <= {num_sh, 16'd0} + 63'(den_sh[46:1]);
			dvs_shf <= den_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_sum <= 1'b0;
			vld_nrm <= 1'b0;
			vld_shf <= 1'b0;
		end else if (en) begin
			vld_s1  <= trait_valid;
			vld_s2  <= vld_s1;
			vld_sum <= vld_x[umrp_pkg::EXP_LAT];
			vld_nrm <= vld_sum;
			vld_shf <= vld_nrm;
		end
	end

	assign req_shf = {vld_shf, dvd_shf, dvs_shf};

	umrp_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .req(req_shf), .q_vld(dq_vld), .q(dq)
	);

	// A result that arrives while the output is stalled parks in the skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !probability_stall) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= dq_vld;
			end
		end else if (en && dq_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !probability_stall) begin
			out_q <= skid_vld_q ? skid_q : sat;
		end else if (en && dq_vld) begin
			skid_q <= sat;
		end
	end

	assign probability_valid = out_vld_q;
	assign probability       = out_q;

endmodule

// ----- rtl/umrp_chk.sv -----
// Port-level checker for the unfolding-model rejection probability block, bound to its top level.
// Depends only on the top level's ports.
module umrp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        trait_stall,
	input logic        probability_valid,
	input logic        probability_stall,
	input logic [15:0] probability
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		probability_valid && probability_stall |=> probability_valid)
		else $error("stalled result withdrawn");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		probability_valid && probability_stall |=> $stable(probability))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		trait_stall |-> $past(probability_valid && probability_stall))
		else $error("input stalled without a stalled result");

	a_stall_valid: assert property (@(posedge clk) disable iff (!arst_n)
		trait_stall |-> probability_valid)
		else $error("input stalled while no result is offered");

endmodule

bind unfolding_model_rejection_probability_top umrp_chk u_umrp_chk (
	.clk(clk), .arst_n(arst_n), .trait_stall(trait_stall),
	.probability_valid(probability_valid), .probability_stall(probability_stall),
	.probability(probability)
);
